/* design/jrf_pkg.sv */
`default_nettype none

package jrf_pkg;

  // Fixed-point shape of the datapath
  localparam int QShift    = 11;
  localparam int QuotW     = 12;
  localparam int MagW      = 17;
  localparam int RemW      = 28;
  localparam int AngW      = 14;
  localparam int OutW      = 13;
  localparam int DivStages = 6;
  localparam int TrigLat   = 3;
  localparam int PipeLat   = 5 + DivStages + TrigLat;
  localparam int HalfPi    = 3216;
  localparam int SegMul    = 2609;

  // Sideband that travels through the divider with each quotient
  typedef struct packed {
    logic neg;
    logic swp;
    logic zero;
  } pair_tag_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MagW-1:0] dv;
    pair_tag_t       tag;
  } div_in_t;

  // Swap test, operand selection and magnitude set-up for one angle
  function automatic div_in_t pair_setup(input logic signed [15:0] num,
                                         input logic signed [15:0] den);
    logic [MagW-1:0] mn;
    logic [MagW-1:0] md;
    logic            sw;
    div_in_t         res;
    mn = num[15] ? MagW'(-{num[15], num}) : MagW'(num);
    md = den[15] ? MagW'(-{den[15], den}) : MagW'(den);
    sw = (mn > md);
    res.rem      = {(sw ? md : mn), 11'b0};
    res.dv       = sw ? mn : md;
    res.tag.neg  = num[15] ^ den[15];
    res.tag.swp  = sw;
    res.tag.zero = (md == '0) && !sw;
    return res;
  endfunction

  function automatic logic [10:0] atan_y(input logic [2:0] i);
    case (i)
      3'd0: atan_y = 11'd0;
      3'd1: atan_y = 11'd254;
      3'd2: atan_y = 11'd501;
      3'd3: atan_y = 11'd734;
      3'd4: atan_y = 11'd949;
      3'd5: atan_y = 11'd1144;
      3'd6: atan_y = 11'd1317;
      default: atan_y = 11'd1472;
    endcase
  endfunction

  function automatic logic [10:0] atan_s(input logic [2:0] i);
    case (i)
      3'd0: atan_s = 11'd2037;
      3'd1: atan_s = 11'd1976;
      3'd2: atan_s = 11'd1864;
      3'd3: atan_s = 11'd1718;
      3'd4: atan_s = 11'd1555;
      3'd5: atan_s = 11'd1391;
      3'd6: atan_s = 11'd1234;
      default: atan_s = 11'd1090;
    endcase
  endfunction

  function automatic logic [11:0] trig_t(input logic [2:0] i);
    case (i)
      3'd0: trig_t = 12'd0;
      3'd1: trig_t = 12'd402;
      3'd2: trig_t = 12'd804;
      3'd3: trig_t = 12'd1206;
      3'd4: trig_t = 12'd1608;
      3'd5: trig_t = 12'd2010;
      3'd6: trig_t = 12'd2412;
      default: trig_t = 12'd2814;
    endcase
  endfunction

  function automatic logic signed [12:0] cos_y(input logic [2:0] i);
    case (i)
      3'd0: cos_y = 13'sd2048;
      3'd1: cos_y = 13'sd2008;
      3'd2: cos_y = 13'sd1892;
      3'd3: cos_y = 13'sd1702;
      3'd4: cos_y = 13'sd1448;
      3'd5: cos_y = 13'sd1137;
      3'd6: cos_y = 13'sd783;
      default: cos_y = 13'sd399;
    endcase
  endfunction

  function automatic logic signed [12:0] cos_s(input logic [2:0] i);
    case (i)
      3'd0: cos_s = -13'sd200;
      3'd1: cos_s = -13'sd593;
      3'd2: cos_s = -13'sd963;
      3'd3: cos_s = -13'sd1297;
      3'd4: cos_s = -13'sd1580;
      3'd5: cos_s = -13'sd1803;
      3'd6: cos_s = -13'sd1956;
      default: cos_s = -13'sd2034;
    endcase
  endfunction

  function automatic logic signed [12:0] sin_y(input logic [2:0] i);
    case (i)
      3'd0: sin_y = 13'sd0;
      3'd1: sin_y = 13'sd399;
      3'd2: sin_y = 13'sd783;
      3'd3: sin_y = 13'sd1137;
      3'd4: sin_y = 13'sd1448;
      3'd5: sin_y = 13'sd1702;
      3'd6: sin_y = 13'sd1892;
      default: sin_y = 13'sd2008;
    endcase
  endfunction

  function automatic logic signed [12:0] sin_s(input logic [2:0] i);
    case (i)
      3'd0: sin_s = 13'sd2034;
      3'd1: sin_s = 13'sd1956;
      3'd2: sin_s = 13'sd1803;
      3'd3: sin_s = 13'sd1580;
      3'd4: sin_s = 13'sd1297;
      3'd5: sin_s = 13'sd963;
      3'd6: sin_s = 13'sd593;
      default: sin_s = 13'sd200;
    endcase
  endfunction

endpackage

`default_nettype wire

/* design/jacobi_rotation_factors_q11_unit.sv */
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_ready   elem_a, elem_b, elem_c, elem_d (16-bit Q11)
// out      out_valid / out_ready left_cos, left_sin, right_cos, right_sin (13-bit)
//
// One transaction per cycle while out is not stalled.
// The pipeline is made up of the two 6-stage radix-4 restoring dividers and the
// 3-stage cosine/sine interpolators, plus five set-up and angle stages.
// rst clears the valid bits only. A stall on out freezes the whole pipeline
// and drops in_ready; nothing is lost or repeated.

module jacobi_rotation_factors_q11_unit
  import jrf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [15:0]      elem_a,
  input  wire logic signed [15:0]      elem_b,
  input  wire logic signed [15:0]      elem_c,
  input  wire logic signed [15:0]      elem_d,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OutW-1:0]       left_cos,
  output logic signed [OutW-1:0]       left_sin,
  output logic signed [OutW-1:0]       right_cos,
  output logic signed [OutW-1:0]       right_sin
);

  logic               en;
  logic [PipeLat-1:0] vld;

  assign en        = !vld[PipeLat-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[PipeLat-1];

  // Shift the valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PipeLat-2:0], in_valid};
    end
  end

  // Stage 1: capture the block
  logic signed [15:0] a_r, b_r, c_r, d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= elem_a;
      b_r <= elem_b;
      c_r <= elem_c;
      d_r <= elem_d;
    end
  end

  // Stage 2: wrapped sums, swap test and divider set-up
  logic signed [15:0] num_sum, den_sum, num_alt, den_alt;
  div_in_t            sum_in, diff_in;

  assign num_sum = c_r + b_r;
  assign den_sum = d_r - a_r;
  assign num_alt = c_r - b_r;
  assign den_alt = d_r + a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_in  <= pair_setup(num_sum, den_sum);
      diff_in <= pair_setup(num_alt, den_alt);
    end
  end

  // Quotient magnitudes
  logic [QuotW-1:0] q_sum, q_diff;
  pair_tag_t        tg_sum, tg_diff;

  jrf_div u_div_sum (
    .clk  (clk),
    .en   (en),
    .din  (sum_in),
    .quot (q_sum),
    .tag  (tg_sum)
  );

  jrf_div u_div_diff (
    .clk  (clk),
    .en   (en),
    .din  (diff_in),
    .quot (q_diff),
    .tag  (tg_diff)
  );

  // Arctan interpolation on a quotient magnitude
  function automatic logic [10:0] atan_mag(input logic [QuotW-1:0] q);
    logic [2:0]  i;
    logic [8:0]  fr;
    logic [19:0] p;
    i  = (q[11:8] > 4'd7) ? 3'd7 : q[10:8];
    fr = 9'(q - {1'b0, i, 8'b0});
    p  = 20'(atan_s(i)) * 20'(fr);
    return atan_y(i) + 11'(p >> QShift);
  endfunction

  // Stage 9: arctan of each quotient
  logic [10:0] r_sum, r_diff;
  pair_tag_t   tg9_sum, tg9_diff;
  always_ff @(posedge clk) begin
    if (en) begin
      r_sum    <= atan_mag(q_sum);
      r_diff   <= atan_mag(q_diff);
      tg9_sum  <= tg_sum;
      tg9_diff <= tg_diff;
    end
  end

  // Sign, swap and zero-divisor rules for one angle
  function automatic logic signed [AngW-1:0] pair_angle(input logic [10:0] r,
                                                        input pair_tag_t t);
    logic signed [AngW-1:0] sr;
    sr = t.neg ? -AngW'(r) : AngW'(r);
    if (t.zero) return AngW'(HalfPi);
    if (t.swp) return AngW'(HalfPi) - sr;
    return sr;
  endfunction

  // Stage 10: pair angles
  logic signed [AngW-1:0] th_sum, th_diff;
  always_ff @(posedge clk) begin
    if (en) begin
      th_sum  <= pair_angle(r_sum, tg9_sum);
      th_diff <= pair_angle(r_diff, tg9_diff);
    end
  end

  // Stage 11: half-difference and half-sum, truncated toward zero
  logic signed [AngW:0]   dl, dr;
  logic signed [AngW-1:0] th_l, th_r;

  assign dl = (AngW+1)'(th_sum) - (AngW+1)'(th_diff);
  assign dr = (AngW+1)'(th_sum) + (AngW+1)'(th_diff);

  always_ff @(posedge clk) begin
    if (en) begin
      th_l <= AngW'((dl + (AngW+1)'(dl[AngW])) >>> 1);
      th_r <= AngW'((dr + (AngW+1)'(dr[AngW])) >>> 1);
    end
  end

  // Stages 12-14: cosine and sine, last stage is the output register
  jrf_trig u_trig_l (
    .clk   (clk),
    .en    (en),
    .theta (th_l),
    .cos_o (left_cos),
    .sin_o (left_sin)
  );

  jrf_trig u_trig_r (
    .clk   (clk),
    .en    (en),
    .theta (th_r),
    .cos_o (right_cos),
    .sin_o (right_sin)
  );

endmodule

`default_nettype wire

/* design/jrf_div.sv */
`default_nettype none

module jrf_div
  import jrf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            en,
  input  wire div_in_t         din,
  output logic [QuotW-1:0]     quot,
  output pair_tag_t            tag
);

  logic [RemW-1:0]  rem_r [DivStages];
  logic [MagW-1:0]  dv_r  [DivStages];
  logic [QuotW-1:0] q_r   [DivStages];
  pair_tag_t        tag_r [DivStages];

  genvar j;
  for (j = 0; j < DivStages; j++) begin : g_st
    logic [RemW-1:0]  r_in, r_mid, r_out, dsh_hi, dsh_lo;
    logic [MagW-1:0]  d_in;
    logic [QuotW-1:0] q_in, q_out;
    pair_tag_t        t_in;

    if (j == 0) begin : g_first
      assign r_in = din.rem;
      assign d_in = din.dv;
      assign q_in = '0;
      assign t_in = din.tag;
    end else begin : g_rest
      assign r_in = rem_r[j-1];
      assign d_in = dv_r[j-1];
      assign q_in = q_r[j-1];
      assign t_in = tag_r[j-1];
    end

    assign dsh_hi = RemW'(d_in) << (QuotW - 1 - 2*j);
    assign dsh_lo = RemW'(d_in) << (QuotW - 2 - 2*j);

    // Two restoring steps: subtract the shifted divisor where it fits
    always_comb begin
      r_mid = r_in;
      r_out = r_in;
      q_out = q_in;
      if (r_in >= dsh_hi) begin
        r_mid = r_in - dsh_hi;
        q_out[QuotW-1-2*j] = 1'b1;
      end
      r_out = r_mid;
      if (r_mid >= dsh_lo) begin
        r_out = r_mid - dsh_lo;
        q_out[QuotW-2-2*j] = 1'b1;
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= r_out;
        dv_r[j]  <= d_in;
        q_r[j]   <= q_out;
        tag_r[j] <= t_in;
      end
    end
  end

  assign quot = q_r[DivStages-1];
  assign tag  = tag_r[DivStages-1];

endmodule

`default_nettype wire

/* design/jrf_trig.sv */
`default_nettype none

module jrf_trig
  import jrf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [AngW-1:0] theta,
  output logic signed [OutW-1:0]      cos_o,
  output logic signed [OutW-1:0]      sin_o
);

  // Stage A: clamp magnitude and form the segment product
  logic [AngW-1:0] mag_a;
  logic [11:0]     t_a;
  logic [11:0]     t_r;
  logic [23:0]     seg_r;
  logic            neg_a;

  assign mag_a = theta[AngW-1] ? AngW'(-theta) : AngW'(theta);
  assign t_a   = (mag_a > AngW'(HalfPi)) ? 12'(HalfPi) : mag_a[11:0];

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= t_a;
      seg_r <= 24'(t_a) * 24'(SegMul);
      neg_a <= theta[AngW-1];
    end
  end

  // Stage B: pick the segment and interpolate both curves
  logic [2:0]               idx;
  logic signed [12:0]       dt;
  logic signed [25:0]       cprod, sprod;
  logic signed [OutW-1:0]   cos_b, sin_b;
  logic                     neg_b;

  assign idx   = (seg_r[23:20] > 4'd7) ? 3'd7 : seg_r[22:20];
  assign dt    = $signed({1'b0, t_r}) - $signed({1'b0, trig_t(idx)});
  assign cprod = 26'(cos_s(idx)) * 26'(dt);
  assign sprod = 26'(sin_s(idx)) * 26'(dt);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_b <= cos_y(idx) + OutW'(cprod >>> QShift);
      sin_b <= sin_y(idx) + OutW'(sprod >>> QShift);
      neg_b <= neg_a;
    end
  end

  // Stage C: apply the sign of the angle to the sine
  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= cos_b;
      sin_o <= neg_b ? -sin_b : sin_b;
    end
  end

endmodule

`default_nettype wire
